// File: hw/rtl/assert_macros.svh
// ============================================================================
// Assertion macros
// Concurrent assertion wrappers used by the line drain unit's brld_back.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property checked on every rising clock edge outside reset.
`define BRLD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("brld assertion failed");
// Antecedent this cycle implies consequent in the following cycle.
`define BRLD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("brld assertion failed");
`else
`define BRLD_ASSERT(lbl, clk, rst_n, prop)
`define BRLD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: hw/rtl/brld_pkg.sv
// ============================================================================
// brld_pkg
// Types and constants shared by the byte ring buffer line drain unit.
// ============================================================================
package brld_pkg;

    typedef enum logic
    {
        CMD_WRITE   = 1'b0,
        CMD_RECEIVE = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        KIND_STATUS = 2'd0,
        KIND_BYTE   = 2'd1,
        KIND_END    = 2'd2
    } kind_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_FETCH,
        ST_EVAL
    } state_t;

    // One decoded request as it travels from the front queue to the engine.
    typedef struct packed
    {
        cmd_t       cmd;
        logic [7:0] data;
    } op_t;

    // One result as it sits in the output register.
    typedef struct packed
    {
        kind_t      kind;
        logic [7:0] data;
        logic       full;
        logic [7:0] count;
        logic       last;
    } res_t;

    localparam logic [7:0] NEWLINE_BYTE   = 8'h0A;
    localparam logic [7:0] LINE_LIMIT_RST = 8'd64;

endpackage

// File: hw/rtl/brld_ram.sv
// ============================================================================
// brld_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module brld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/brld_front.sv
// ============================================================================
// brld_front
// Accepts requests, decodes the command and holds them in a two-entry queue.
// ============================================================================
module brld_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic           command,
    input  logic [7:0]     byte_in,
    output logic           op_valid,
    output brld_pkg::op_t  op,
    input  logic           op_take
);

    brld_pkg::op_t q_reg [2];
    logic          wr_idx_reg;
    logic          rd_idx_reg;
    logic [1:0]    cnt_reg;
    logic          push;
    logic          pop;

    assign in_stall = (cnt_reg == 2'd2);
    assign op_valid = (cnt_reg != 2'd0);
    assign op       = q_reg[rd_idx_reg];
    assign push     = in_valid && !in_stall;
    assign pop      = op_valid && op_take;

    // Payload entries need no reset; only entries counted as held are read.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_idx_reg].cmd  <= brld_pkg::cmd_t'(command);
            q_reg[wr_idx_reg].data <= (brld_pkg::cmd_t'(command) == brld_pkg::CMD_WRITE)
                                      ? byte_in : 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= 1'b0;
            rd_idx_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_idx_reg <= ~wr_idx_reg;
            end
            if (pop)
            begin
                rd_idx_reg <= ~rd_idx_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

// File: hw/rtl/brld_back.sv
// ============================================================================
// brld_back
// Executes write and receive requests against the ring and drives results.
// ============================================================================
`include "assert_macros.svh"

module brld_back #(
    parameter int DEPTH = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           op_valid,
    input  brld_pkg::op_t  op,
    output logic           op_take,
    input  logic           cfg_wr_en,
    input  logic [7:0]     cfg_wr_data,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [1:0]     kind,
    output logic [7:0]     byte_out,
    output logic           full_error,
    output logic [7:0]     line_count,
    output logic           last
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);

    brld_pkg::state_t state_reg;
    brld_pkg::state_t state_next;
    logic [PTR_W-1:0] wp_reg;
    logic [PTR_W-1:0] rp_reg;
    logic [PTR_W-1:0] fill_reg;
    logic [7:0]       count_reg;
    logic [7:0]       line_limit_reg;
    logic             out_valid_reg;
    brld_pkg::res_t   res_reg;
    brld_pkg::res_t   res_next;

    logic             can_emit;
    logic             emit;
    logic             store;
    logic             consume;
    logic             count_clr;
    logic             count_inc;
    logic             ram_re;
    logic [7:0]       ram_q;
    logic             line_done;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] n;
        n = (p == PTR_MAX) ? '0 : p + PTR_W'(1);
        return n;
    endfunction

    assign can_emit  = !out_valid_reg || !out_stall;
    assign line_done = (ram_q == brld_pkg::NEWLINE_BYTE) || (count_reg >= line_limit_reg);

    brld_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk     (clk),
        .we      (store),
        .wr_addr (wp_reg),
        .wr_data (op.data),
        .re      (ram_re),
        .rd_addr (rp_reg),
        .rd_data (ram_q)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            brld_pkg::ST_IDLE:
            begin
                if (op_valid && op.cmd == brld_pkg::CMD_RECEIVE)
                begin
                    state_next = brld_pkg::ST_FETCH;
                end
            end
            brld_pkg::ST_FETCH:
            begin
                if (fill_reg == '0)
                begin
                    if (can_emit)
                    begin
                        state_next = brld_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    state_next = brld_pkg::ST_EVAL;
                end
            end
            brld_pkg::ST_EVAL:
            begin
                if (can_emit)
                begin
                    state_next = line_done ? brld_pkg::ST_IDLE : brld_pkg::ST_FETCH;
                end
            end
            default:
            begin
                state_next = brld_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op_take        = 1'b0;
        emit           = 1'b0;
        store          = 1'b0;
        consume        = 1'b0;
        count_clr      = 1'b0;
        count_inc      = 1'b0;
        ram_re         = 1'b0;
        res_next.kind  = brld_pkg::KIND_STATUS;
        res_next.data  = 8'd0;
        res_next.full  = 1'b0;
        res_next.count = 8'd0;
        res_next.last  = 1'b0;
        case (state_reg)
            brld_pkg::ST_IDLE:
            begin
                if (op_valid)
                begin
                    if (op.cmd == brld_pkg::CMD_WRITE)
                    begin
                        if (can_emit)
                        begin
                            op_take       = 1'b1;
                            emit          = 1'b1;
                            res_next.last = 1'b1;
                            if (fill_reg == PTR_MAX)
                            begin
                                res_next.full = 1'b1;
                            end
                            else
                            begin
                                store = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        op_take   = 1'b1;
                        count_clr = 1'b1;
                    end
                end
            end
            brld_pkg::ST_FETCH:
            begin
                if (fill_reg == '0)
                begin
                    if (can_emit)
                    begin
                        emit           = 1'b1;
                        res_next.kind  = brld_pkg::KIND_END;
                        res_next.count = count_reg;
                        res_next.last  = 1'b1;
                    end
                end
                else
                begin
                    ram_re = 1'b1;
                end
            end
            brld_pkg::ST_EVAL:
            begin
                if (can_emit)
                begin
                    consume = 1'b1;
                    emit    = 1'b1;
                    if (line_done)
                    begin
                        res_next.kind  = brld_pkg::KIND_END;
                        res_next.count = count_reg;
                        res_next.last  = 1'b1;
                    end
                    else
                    begin
                        res_next.kind = brld_pkg::KIND_BYTE;
                        res_next.data = ram_q;
                        count_inc     = 1'b1;
                    end
                end
            end
            default:
            begin
                op_take = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= brld_pkg::ST_IDLE;
            wp_reg         <= '0;
            rp_reg         <= '0;
            fill_reg       <= '0;
            count_reg      <= 8'd0;
            line_limit_reg <= brld_pkg::LINE_LIMIT_RST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                line_limit_reg <= cfg_wr_data;
            end
            if (store)
            begin
                wp_reg   <= ptr_inc(wp_reg);
                fill_reg <= fill_reg + PTR_W'(1);
            end
            else if (consume)
            begin
                rp_reg   <= ptr_inc(rp_reg);
                fill_reg <= fill_reg - PTR_W'(1);
            end
            if (count_clr)
            begin
                count_reg <= 8'd0;
            end
            else if (count_inc)
            begin
                count_reg <= count_reg + 8'd1;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = res_reg.kind;
    assign byte_out   = res_reg.data;
    assign full_error = res_reg.full;
    assign line_count = res_reg.count;
    assign last       = res_reg.last;

    // The ring never holds more than one entry short of its depth.
    `BRLD_ASSERT(a_fill_bound, clk, rst_n, fill_reg <= PTR_MAX)
    // The fill count agrees with the pointer distance around the ring.
    `BRLD_ASSERT(a_fill_ptrs, clk, rst_n,
        ((wp_reg >= rp_reg) ? (int'(wp_reg) - int'(rp_reg))
                            : (int'(wp_reg) + DEPTH - int'(rp_reg))) == int'(fill_reg))
    // Evaluation only ever follows a ring read.
    `BRLD_ASSERT(a_eval_entry, clk, rst_n,
        (state_reg == brld_pkg::ST_EVAL) |->
            ($past(state_reg) == brld_pkg::ST_FETCH || $past(state_reg) == brld_pkg::ST_EVAL))
    // Read data must survive while a drained byte waits for the output.
    `BRLD_ASSERT_NEXT(a_rdata_hold, clk, rst_n,
        state_reg == brld_pkg::ST_EVAL && !can_emit, $stable(ram_q))
    // A line end never reports more bytes than the limit allows.
    `BRLD_ASSERT(a_end_count, clk, rst_n,
        (out_valid_reg && res_reg.kind == brld_pkg::KIND_END) |->
            (res_reg.count <= line_limit_reg))

endmodule

// File: hw/rtl/byte_ring_buffer_line_drain_unit.sv
// ============================================================================
// byte_ring_buffer_line_drain_unit
// Byte receive ring buffer that stores written bytes and drains them by line.
// ============================================================================
//
//   Channel   Signals                                       Direction
//   -------   -------------------------------------------   ---------
//   input     in_valid, in_stall, command, byte_in          request in
//   output    out_valid, out_stall, kind, byte_out,         result out
//             full_error, line_count, last
//   config    cfg_wr_en, cfg_wr_data (line_limit)           write only
//
// A write request produces one status result. A receive request is taken in
// the idle state, then every byte read from the ring passes through a fetch
// (a registered RAM read) and an evaluation; on an empty ring the fetch
// state ends the line instead.
// Reset clears the pointers, the fill count and line_limit (to 64); the ring
// contents are left as they are and need no clearing pass.
// A stalled output holds the engine, while the two-entry request queue in front
// keeps accepting requests until it fills.
//
// The front part decodes requests into a small queue; the back part owns the
// ring, its pointers and the output register, so a stall on either side does
// not reach the other until the queue fills or drains.
module byte_ring_buffer_line_drain_unit #(
    parameter int DEPTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       command,
    input  logic [7:0] byte_in,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] kind,
    output logic [7:0] byte_out,
    output logic       full_error,
    output logic [7:0] line_count,
    output logic       last,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data
);

    // Decoded request handed from the queue to the engine.
    logic          op_valid;
    logic          op_take;
    brld_pkg::op_t op;

    brld_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .command  (command),
        .byte_in  (byte_in),
        .op_valid (op_valid),
        .op       (op),
        .op_take  (op_take)
    );

    // The engine walks the ring one byte at a time and stops on a newline, an
    // empty ring, or after line_limit bytes (consuming one more byte then).
    brld_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .op_valid    (op_valid),
        .op          (op),
        .op_take     (op_take),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .byte_out    (byte_out),
        .full_error  (full_error),
        .line_count  (line_count),
        .last        (last)
    );

endmodule

// File: bench/byte_ring_buffer_line_drain_unit_checker.sv
// ----------------------------------------------------------------------------
// Line drain unit checker
// Watches the request, result and register channels of the line drain unit,
// keeps its own copy of the ring, pointers and line limit, and compares each
// result with the oldest predicted one.
// ----------------------------------------------------------------------------
module byte_ring_buffer_line_drain_unit_checker #(
    parameter int DEPTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic       command,
    input  logic [7:0] byte_in,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [1:0] kind,
    input  logic [7:0] byte_out,
    input  logic       full_error,
    input  logic [7:0] line_count,
    input  logic       last,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    output int         mismatches,
    output int         awaited,
    output int         results_seen,
    output int         refused_writes,
    output int         line_bytes
);
    timeunit 1ns;
    timeprecision 1ps;

    import brld_pkg::*;

    logic [7:0] ring_copy [DEPTH];
    int         fill_idx = 0;
    int         drain_idx = 0;
    logic [7:0] limit_copy = LINE_LIMIT_RST;
    res_t       pending_results [$];

    initial
    begin
        mismatches     = 0;
        awaited        = 0;
        results_seen   = 0;
        refused_writes = 0;
        line_bytes     = 0;
    end

    function automatic int bytes_held();
        return (fill_idx - drain_idx + DEPTH) % DEPTH;
    endfunction

    // An empty ring reads as a newline and leaves the read pointer alone.
    function automatic logic [7:0] take_byte();
        logic [7:0] b;
        if (bytes_held() == 0)
            return NEWLINE_BYTE;
        b = ring_copy[drain_idx];
        drain_idx = (drain_idx + 1) % DEPTH;
        return b;
    endfunction

    task automatic predict_request(input cmd_t cmd, input logic [7:0] data);
        logic [7:0] b;
        logic [7:0] emitted;
        emitted = 8'd0;
        if (cmd == CMD_WRITE)
        begin
            if (bytes_held() == DEPTH - 1)
                pending_results.push_back(res_t'{KIND_STATUS, 8'h00, 1'b1, 8'h00, 1'b1});
            else
            begin
                ring_copy[fill_idx] = data;
                fill_idx = (fill_idx + 1) % DEPTH;
                pending_results.push_back(res_t'{KIND_STATUS, 8'h00, 1'b0, 8'h00, 1'b1});
            end
        end
        else
        begin
            // Once the limit is reached one further byte is still taken and dropped.
            b = take_byte();
            while (b != NEWLINE_BYTE && emitted < limit_copy)
            begin
                pending_results.push_back(res_t'{KIND_BYTE, b, 1'b0, 8'h00, 1'b0});
                emitted = emitted + 8'd1;
                b = take_byte();
            end
            pending_results.push_back(res_t'{KIND_END, 8'h00, 1'b0, emitted, 1'b1});
        end
    endtask

    task automatic report_result(input string why, input bit have_exp, input res_t exp,
                                 input res_t got);
        if (mismatches < 10)
        begin
            if (have_exp)
                $display("%t result %0d %s: expected kind=%0d byte=%02h full=%0b count=%0d last=%0b",
                         $realtime, results_seen, why, exp.kind, exp.data, exp.full,
                         exp.count, exp.last);
            $display("%t result %0d %s: got      kind=%0d byte=%02h full=%0b count=%0d last=%0b",
                     $realtime, results_seen, why, got.kind, got.data, got.full,
                     got.count, got.last);
        end
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        res_t got;
        res_t exp;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = res_t'{kind_t'(kind), byte_out, full_error, line_count, last};
                results_seen++;
                if (pending_results.size() == 0)
                    report_result("with nothing expected", 1'b0, got, got);
                else
                begin
                    exp = pending_results.pop_front();
                    if (got.kind !== exp.kind || got.data !== exp.data ||
                        got.full !== exp.full || got.count !== exp.count ||
                        got.last !== exp.last)
                        report_result("mismatch", 1'b1, exp, got);
                    else if (got.kind == KIND_BYTE)
                        line_bytes++;
                    else if (got.full)
                        refused_writes++;
                end
            end
            if (in_valid && !in_stall)
                predict_request(cmd_t'(command), byte_in);
            if (cfg_wr_en)
                limit_copy = cfg_wr_data;
            awaited = pending_results.size();
        end
    end

endmodule

// File: bench/byte_ring_buffer_line_drain_unit_tb.sv
// ----------------------------------------------------------------------------
// Line drain unit testbench
// Drives write and receive requests into the byte ring buffer, varies the
// line limit between phases and stalls both channels at random, including
// one long output hold-off that backs the request queue up. A separate
// checker predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module byte_ring_buffer_line_drain_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import brld_pkg::*;

    localparam int DEPTH           = 64;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int WATCHDOG_LIMIT  = 3000;
    // Settling time before a register write and after the last result.
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 20;
    // Requests the whole run aims for, the directed part included.
    localparam int REQUEST_TARGET  = 110;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic       command;
    logic [7:0] byte_in;
    logic       out_valid;
    logic       out_stall;
    logic [1:0] kind;
    logic [7:0] byte_out;
    logic       full_error;
    logic [7:0] line_count;
    logic       last;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;

    int mismatches;
    int awaited;
    int results_seen;
    int refused_writes;
    int line_bytes;

    // Stimulus-side controls. Each is written by one process only.
    bit sender_idle_on;
    bit receiver_idle_on;
    bit hold_off_req;
    bit hold_off_done;
    int requests_sent;

    always #5ns clk = ~clk;

    byte_ring_buffer_line_drain_unit #(
        .DEPTH(DEPTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .byte_in    (byte_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .byte_out   (byte_out),
        .full_error (full_error),
        .line_count (line_count),
        .last       (last),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    byte_ring_buffer_line_drain_unit_checker #(
        .DEPTH(DEPTH)
    ) line_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .byte_in       (byte_in),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .byte_out      (byte_out),
        .full_error    (full_error),
        .line_count    (line_count),
        .last          (last),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .mismatches    (mismatches),
        .awaited       (awaited),
        .results_seen  (results_seen),
        .refused_writes(refused_writes),
        .line_bytes    (line_bytes)
    );

    // Offers one request and returns at the falling edge after it has been
    // taken. The payload is only changed at a falling edge, and valid stays
    // high from one request to the next unless an idle gap is drawn, so it is
    // never dropped and raised within one time step.
    task automatic send_request(input cmd_t cmd, input logic [7:0] data);
        while (sender_idle_on && $urandom_range(0, 99) < 36)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        byte_in  <= data;
        do
            @(posedge clk);
        while (in_stall);
        requests_sent++;
        @(negedge clk);
    endtask

    // The line limit may only change while the unit is idle, so the sender
    // stops, every predicted result is collected, and the engine is given a
    // settling time before the write.
    task automatic set_line_limit(input logic [7:0] limit);
        in_valid <= 1'b0;
        while (awaited != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= limit;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Line content: a newline about one time in eight, so that lines end in
    // the buffer as well as on the limit or on an empty ring.
    function automatic logic [7:0] line_byte();
        if ($urandom_range(0, 7) == 0)
            return NEWLINE_BYTE;
        return 8'($urandom_range(0, 255));
    endfunction

    // Any byte but a newline, for phases where a receive must drain everything.
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == NEWLINE_BYTE)
            b = ~b;
        return b;
    endfunction

    // A typical exchange: a burst of received bytes followed by one or two
    // receive requests. The byte field of a receive is ignored by the unit but
    // is still randomised.
    task automatic send_line_burst();
        int burst_len;
        int reads;
        burst_len = $urandom_range(0, 10);
        reads     = $urandom_range(1, 2);
        repeat (burst_len) send_request(CMD_WRITE, line_byte());
        if ($urandom_range(0, 1) == 0)
            send_request(CMD_WRITE, NEWLINE_BYTE);
        repeat (reads) send_request(CMD_RECEIVE, 8'($urandom_range(0, 255)));
    endtask

    // Receiver: random stalls, or one long hold-off when asked for. The
    // hold-off is counted here so that the sender keeps offering requests
    // while the output is blocked and the request queue fills behind it.
    initial
    begin : receiver
        int held;
        held          = 0;
        out_stall     = 1'b0;
        hold_off_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req && !hold_off_done)
            begin
                out_stall <= 1'b1;
                held++;
                if (held == HOLD_OFF_CYCLES)
                    hold_off_done = 1'b1;
            end
            else
                out_stall <= receiver_idle_on && ($urandom_range(0, 99) < 36);
        end
    end

    // Ends the run if neither channel completes a handshake for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog: no handshake for %0d cycles, %0d results outstanding.",
                 WATCHDOG_LIMIT, awaited);
        $display("[byte_ring_buffer_line_drain_unit] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int phase_end;
        int pick;
        logic [7:0] phase_limit;

        rst_n            = 1'b0;
        in_valid         = 1'b0;
        command          = CMD_WRITE;
        byte_in          = 8'h00;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = 8'h00;
        sender_idle_on   = 1'b1;
        receiver_idle_on = 1'b1;
        hold_off_req     = 1'b0;
        requests_sent    = 0;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset limit of 64. A receive on an empty ring
        // ends the line at once with a count of zero.
        send_request(CMD_RECEIVE, 8'h00);
        // The first receive stops at the stored newline, which is consumed but
        // not emitted; the second runs the ring dry.
        send_request(CMD_WRITE, 8'h00);
        send_request(CMD_WRITE, 8'hFF);
        send_request(CMD_WRITE, NEWLINE_BYTE);
        send_request(CMD_WRITE, 8'h55);
        send_request(CMD_WRITE, 8'hAA);
        send_request(CMD_RECEIVE, 8'hFF);
        send_request(CMD_RECEIVE, 8'h00);

        // With a limit of zero no byte is emitted, yet each receive still
        // swallows one byte while there is one to take.
        set_line_limit(8'd0);
        send_request(CMD_WRITE, 8'h41);
        send_request(CMD_WRITE, 8'h42);
        send_request(CMD_RECEIVE, 8'h00);
        send_request(CMD_RECEIVE, 8'h00);
        send_request(CMD_RECEIVE, 8'h00);

        // Limit reached part way through a line: the byte after the limit is
        // dropped, and the newline left behind makes an empty line.
        set_line_limit(8'd2);
        send_request(CMD_WRITE, 8'h31);
        send_request(CMD_WRITE, 8'h32);
        send_request(CMD_WRITE, 8'h33);
        send_request(CMD_WRITE, NEWLINE_BYTE);
        send_request(CMD_RECEIVE, 8'h00);
        send_request(CMD_RECEIVE, 8'h00);

        // Back-pressure: the output is held off while writes keep coming, so
        // the request queue fills and the input stalls.
        set_line_limit(8'd255);
        hold_off_req = 1'b1;
        while (!hold_off_done)
            send_request(CMD_WRITE, plain_byte());

        // A long stretch with no idling on either side: fill the ring past
        // full so that writes are refused, then drain the whole of it in a
        // single line of the largest size.
        sender_idle_on   = 1'b0;
        receiver_idle_on = 1'b0;
        repeat (DEPTH + 2) send_request(CMD_WRITE, plain_byte());
        send_request(CMD_RECEIVE, 8'($urandom_range(0, 255)));
        send_request(CMD_RECEIVE, 8'($urandom_range(0, 255)));
        sender_idle_on   = 1'b1;
        receiver_idle_on = 1'b1;

        // Random part in four phases, each with its own line limit, sharing
        // out what is left of the request budget. Most of the traffic is
        // bursts of bytes closed by receives; the rest is lone requests of
        // either kind.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       phase_limit = 8'd1;
                1:       phase_limit = 8'($urandom_range(2, 20));
                2:       phase_limit = 8'd255;
                default: phase_limit = 8'($urandom_range(0, 255));
            endcase
            set_line_limit(phase_limit);
            phase_end = requests_sent + (REQUEST_TARGET - requests_sent) / (4 - phase);
            while (requests_sent < phase_end)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    send_line_burst();
                else if (pick < 9)
                    send_request(CMD_RECEIVE, 8'($urandom_range(0, 255)));
                else
                    send_request(CMD_WRITE, 8'($urandom_range(0, 255)));
            end
        end

        // Collect what is still owed, then watch a little longer for strays.
        in_valid <= 1'b0;
        while (awaited != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d requests and %0d results: %0d line bytes, %0d writes refused as full.",
                 requests_sent, results_seen, line_bytes, refused_writes);
        $display("Line limits 0, 1, 2, 64, 255 and random ones, random stalls and a %0d-cycle hold-off.",
                 HOLD_OFF_CYCLES);
        if (awaited != 0)
            $display("%0d expected results never arrived.", awaited);
        if (mismatches == 0 && awaited == 0)
            $display("[byte_ring_buffer_line_drain_unit] OK");
        else
            $display("[byte_ring_buffer_line_drain_unit] ERROR");
        $finish;
    end

endmodule

// File: byte_ring_buffer_line_drain_unit.f
+incdir+hw/rtl
hw/rtl/brld_pkg.sv
hw/rtl/brld_ram.sv
hw/rtl/brld_front.sv
hw/rtl/brld_back.sv
hw/rtl/byte_ring_buffer_line_drain_unit.sv
bench/byte_ring_buffer_line_drain_unit_checker.sv
bench/byte_ring_buffer_line_drain_unit_tb.sv
